>>> hdl/srtf_heap_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
// Included by the files that carry concurrent assertions.
`ifndef SRTF_HEAP_SCHEDULER_MACROS_SVH
`define SRTF_HEAP_SCHEDULER_MACROS_SVH
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRTF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/srtf_pkg.sv
// Types and constants of the SRTF heap scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package srtf_pkg;
  localparam int unsigned HeapDepthDef = 128;
  localparam logic [47:0] WaitMax = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_RUN    = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  localparam logic ModeArrival = 1'b0;
  localparam logic ModeTick    = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] arr;
    logic [15:0] full;
    logic [15:0] rem;
  } entry_t;
endpackage

>>> hdl/srtf_heap_scheduler.sv
// Top level of the SRTF heap scheduler: sequencer, state and output register.
// Depends on srtf_pkg, srtf_mem, srtf_rank and the macros header.
//
// channel | dir | tdata (low bit up)                               | tuser
// s_axis  | in  | job_id[15:0], job_length[31:16]                  | mode
// m_axis  | out | run_id[15:0], job_finished[16], total_wait[64:17],| kind[1:0]
//         |     | queued_count[72:65], zero[79:73]                 |
//
// One beat at a time: a drop or idle tick goes straight to the result, another
// tick runs the root, an insert climbs one level per parent read and compare, and a
// finishing tick sinks the last entry level by level; registered reads pace these.
// Reset clears count, tick and wait total; the heap memory has no reset.
// The input stays ready in idle even while a result waits on m_axis; the
// next result holds in the sequencer until the output register is free.
`timescale 1ns / 1ps
`include "srtf_heap_scheduler_macros.svh"
module srtf_heap_scheduler import srtf_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = HeapDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // job_id, job_length
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // run_id, job_finished, total_wait, queued_count
  output logic [1:0]  m_axis_tuser    // kind
);
  localparam int unsigned Iw = $clog2(HEAP_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_UP_RD  = 9'b000000010,
    S_UP_CMP = 9'b000000100,
    S_ROOT   = 9'b000001000,
    S_LAST   = 9'b000010000,
    S_DN_RD  = 9'b000100000,
    S_DN_L   = 9'b001000000,
    S_DN_R   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [Iw:0]   count_q, count_d;
  logic [31:0]   tick_q, tick_d;
  logic [47:0]   wait_q, wait_d;
  logic [Iw-1:0] pos_q, pos_d;
  entry_t        cur_q, cur_d;
  entry_t        best_q, best_d;
  logic          bsel_q, bsel_d;
  logic          rv_q, rv_d;
  kind_e         kind_q, kind_d;
  logic [15:0]   rid_q, rid_d;
  logic          fin_q, fin_d;

  logic        out_valid_q, out_valid_d;
  logic [79:0] out_data_q, out_data_d;
  kind_e       out_kind_q, out_kind_d;

  logic          we, re;
  logic [Iw-1:0] waddr, raddr_a, raddr_b;
  entry_t        wdata, rd_a, rd_b;
  entry_t        cmp_a, cmp_b;
  logic          a_first;

  logic          in_fire;
  logic [Iw:0]   lidx, ridx, newc;
  logic [31:0]   delay;
  logic [48:0]   wsum;
  logic [Iw+8:0] qext;
  logic [15:0]   nrem;

  srtf_mem #(.Depth(HEAP_DEPTH), .Iw(Iw)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .re_i(re),
    .raddr_a_i(raddr_a), .raddr_b_i(raddr_b), .rdata_a_o(rd_a), .rdata_b_o(rd_b)
  );

  srtf_rank u_rank (.a_i(cmp_a), .b_i(cmp_b), .a_first_o(a_first));

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // Children of the current hole, one bit wider than an index.
  assign lidx  = {pos_q, 1'b1};
  assign ridx  = lidx + (Iw+1)'(1);
  assign newc  = count_q - (Iw+1)'(1);
  assign delay = tick_q - rd_a.arr;
  assign wsum  = {1'b0, wait_q} + {17'd0, delay};
  assign nrem  = rd_a.rem - 16'd1;
  assign qext  = {8'd0, count_q};

  // Route the single compare unit by sequencer step.
  always_comb begin
    cmp_a = rd_a;
    cmp_b = cur_q;
    case (state_q)
      S_UP_CMP: begin
        cmp_a = cur_q;
        cmp_b = rd_a;
      end
      S_DN_R: begin
        cmp_a = rd_b;
        cmp_b = best_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    tick_d  = tick_q;
    wait_d  = wait_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    best_d  = best_q;
    bsel_d  = bsel_q;
    rv_d    = rv_q;
    kind_d  = kind_q;
    rid_d   = rid_q;
    fin_d   = fin_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = cur_q;
    re      = 1'b0;
    raddr_a = '0;
    raddr_b = '0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          rid_d = '0;
          fin_d = 1'b0;
          if (s_axis_tuser == ModeArrival) begin
            if (s_axis_tdata[31:16] == 16'd0 || count_q >= (Iw+1)'(HEAP_DEPTH)) begin
              kind_d  = KIND_DROP;
              state_d = S_DONE;
            end else begin
              kind_d   = KIND_ACCEPT;
              cur_d.id   = s_axis_tdata[15:0];
              cur_d.arr  = tick_q;
              cur_d.full = s_axis_tdata[31:16];
              cur_d.rem  = s_axis_tdata[31:16];
              pos_d   = count_q[Iw-1:0];
              count_d = count_q + (Iw+1)'(1);
              state_d = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              kind_d  = KIND_IDLE;
              tick_d  = tick_q + 32'd1;
              state_d = S_DONE;
            end else begin
              kind_d  = KIND_RUN;
              re      = 1'b1;
              state_d = S_ROOT;
            end
          end
        end
      end
      // Climb: fetch the parent of the hole.
      S_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          raddr_a = (pos_q - Iw'(1)) >> 1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (a_first) begin
          wdata   = rd_a;
          pos_d   = (pos_q - Iw'(1)) >> 1;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      // Run the root one unit; charge the wait on its first run.
      S_ROOT: begin
        rid_d  = rd_a.id;
        tick_d = tick_q + 32'd1;
        if (rd_a.rem == rd_a.full) begin
          wait_d = wsum[48] ? WaitMax : wsum[47:0];
        end
        if (nrem != 16'd0) begin
          we        = 1'b1;
          waddr     = '0;
          wdata     = rd_a;
          wdata.rem = nrem;
          state_d   = S_DONE;
        end else begin
          fin_d   = 1'b1;
          count_d = newc;
          if (newc == '0) begin
            state_d = S_DONE;
          end else begin
            re      = 1'b1;
            raddr_a = newc[Iw-1:0];
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        cur_d   = rd_a;
        pos_d   = '0;
        state_d = S_DN_RD;
      end
      // Sink: fetch both children of the hole.
      S_DN_RD: begin
        if (lidx >= count_q) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          raddr_a = lidx[Iw-1:0];
          raddr_b = ridx[Iw-1:0];
          rv_d    = ridx < count_q;
          state_d = S_DN_L;
        end
      end
      S_DN_L: begin
        best_d  = a_first ? rd_a : cur_q;
        bsel_d  = a_first;
        state_d = S_DN_R;
      end
      S_DN_R: begin
        we = 1'b1;
        if (rv_q && a_first) begin
          wdata   = rd_b;
          pos_d   = ridx[Iw-1:0];
          state_d = S_DN_RD;
        end else if (bsel_q) begin
          wdata   = rd_a;
          pos_d   = lidx[Iw-1:0];
          state_d = S_DN_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_kind_d  = kind_q;
          out_data_d  = {7'd0, qext[7:0], wait_q, fin_q, rid_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      tick_q      <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      tick_q      <= tick_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cur_q      <= cur_d;
    best_q     <= best_d;
    bsel_q     <= bsel_d;
    rv_q       <= rv_d;
    kind_q     <= kind_d;
    rid_q      <= rid_d;
    fin_q      <= fin_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
  end

  `SRTF_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= (Iw+1)'(HEAP_DEPTH), "heap count over depth")
  `SRTF_ASSERT_NEXT(a_busy_after_beat, in_fire, state_q != S_IDLE, "sequencer idle after a beat")
  `SRTF_ASSERT_IMPL(a_run_fields, out_valid_q && out_kind_q != KIND_RUN, out_data_q[16:0] == 17'd0, "run fields set on a non-run result")
  `SRTF_ASSERT_IMPL(a_hole_in_heap, state_q == S_DN_R, {1'b0, pos_q} < count_q, "sift-down hole outside heap")
endmodule

>>> hdl/srtf_mem.sv
// Heap storage: one write port, two registered read ports.
// Depends on srtf_pkg for the entry record.
`timescale 1ns / 1ps
module srtf_mem import srtf_pkg::*; #(
  parameter int unsigned Depth = HeapDepthDef,
  parameter int unsigned Iw    = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Iw-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [Iw-1:0] raddr_a_i,
  input  logic [Iw-1:0] raddr_b_i,
  output entry_t        rdata_a_o,
  output entry_t        rdata_b_o
);
  entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end
endmodule

>>> hdl/srtf_rank.sv
// Shared priority compare: remaining length first, then job id.
// Depends on srtf_pkg for the entry record.
`timescale 1ns / 1ps
module srtf_rank import srtf_pkg::*; (
  input  entry_t a_i,
  input  entry_t b_i,
  output logic   a_first_o
);
  always_comb begin
    if (a_i.rem != b_i.rem) begin
      a_first_o = a_i.rem < b_i.rem;
    end else begin
      a_first_o = a_i.id < b_i.id;
    end
  end
endmodule
